// ===== rtl/gnsst_pkg.sv =====
// Shared constants and types for the GNSS node slot tracker.
`default_nettype none

package gnsst_pkg;

	// Width of a slot index inside the scan beat; covers the largest table (64 slots).
	localparam int IDX_W = 6;

	localparam int           SLOTS_DEF       = 8;
	localparam logic [7:0]   DISABLED_ID_DEF = 8'd255;
	localparam logic [7:0]   AUTO_ID_DEF     = 8'd0;
	localparam logic [15:0]  TIMEOUT_RST     = 16'd1000;

	localparam logic [1:0] MODE_FIX   = 2'd0;
	localparam logic [1:0] MODE_AUX   = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	localparam logic [1:0] CFG_ENABLE  = 2'd0;
	localparam logic [1:0] CFG_CHOSEN  = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT = 2'd2;

	// Search beat that walks the slot chain one cell per cycle.
	typedef struct packed {
		logic             active;
		logic             done;
		logic             match;
		logic             vvalid;
		logic [IDX_W-1:0] idx;
		logic [7:0]       node_id;
		logic [31:0]      vtime;
		logic [31:0]      hit_time;
		logic [31:0]      hit_pkts;
	} scan_rec_t;

	// Slot write broadcast to every cell.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [7:0]       node;
		logic [31:0]      time_ms;
		logic [31:0]      pkts;
	} slot_wr_t;

endpackage

`default_nettype wire

// ===== rtl/gnsst_cell.sv =====
// One slot of the tracker table with its stage of the search chain.
`default_nettype none

module gnsst_cell #(
	parameter int         INDEX       = 0,
	parameter logic [7:0] DISABLED_ID = 8'd255
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire gnsst_pkg::scan_rec_t rec_in,
	output gnsst_pkg::scan_rec_t      rec_out,
	input  wire gnsst_pkg::slot_wr_t  wr
);
	import gnsst_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [7:0]  node_q;
	logic [31:0] time_q;
	logic [31:0] pkts_q;
	scan_rec_t   rec_nxt;
	scan_rec_t   rec_q;

	always_comb begin
		rec_nxt = rec_in;
		if (rec_in.active && !rec_in.done) begin
			if (node_q == rec_in.node_id) begin
				rec_nxt.done     = 1'b1;
				rec_nxt.match    = 1'b1;
				rec_nxt.idx      = MY_IDX;
				rec_nxt.hit_time = time_q;
				rec_nxt.hit_pkts = pkts_q;
			end else if (node_q == DISABLED_ID) begin
				// empty slot ends the search and becomes the allocation target
				rec_nxt.done = 1'b1;
				rec_nxt.idx  = MY_IDX;
			end else if (!rec_in.vvalid || time_q < rec_in.vtime) begin
				rec_nxt.vvalid = 1'b1;
				rec_nxt.idx    = MY_IDX;
				rec_nxt.vtime  = time_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			rec_q <= rec_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= DISABLED_ID;
			time_q <= '0;
			pkts_q <= '0;
		end else if (wr.en && wr.idx == MY_IDX) begin
			node_q <= wr.node;
			time_q <= wr.time_ms;
			pkts_q <= wr.pkts;
		end
	end

	assign rec_out = rec_q;

endmodule

`default_nettype wire

// ===== rtl/gnss_node_slot_tracker_unit.sv =====
// Top level of the GNSS node slot tracker: control, primary selection and result register.
//
// Input channel (in_valid/in_ready) takes one beat of mode, node_id and now_ms.
// Output channel (out_valid/out_ready) returns exactly one result beat per input.
// Configuration channel (cfg_valid/cfg_ready) writes gps_enabled (index 0),
// chosen_node (1) and timeout_ms (2); cfg_ready is always high, other indexes
// are dropped. Write configuration only while no item is in flight.
// A lookup sends a search beat down a chain of SLOTS cells, one cell per
// cycle; each cell holds one slot and updates the running match/victim.
// The chain walk dominates the work per item: an item passes the launch register,
// the SLOTS cells and the captured hit register before the decision writes the
// result register, and the next item is accepted only after that. Refused IDs
// (0 and DISABLED_ID) and the unused mode skip the chain and go straight to the decision.
// One item is in work at a time; a new item is accepted while the previous
// result still waits in the output register, and the new result is held
// back until that register is free.
// Reset empties all slots, clears the primary node and loads the register
// defaults (disabled, auto choice, 1000 ms timeout); no clearing pass.
`default_nettype none

module gnss_node_slot_tracker_unit #(
	parameter int         SLOTS       = gnsst_pkg::SLOTS_DEF,
	parameter logic [7:0] DISABLED_ID = gnsst_pkg::DISABLED_ID_DEF,
	parameter logic [7:0] AUTO_ID     = gnsst_pkg::AUTO_ID_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  node_id,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             slot_found,
	output logic [2:0]       slot_index,
	output logic             slot_new,
	output logic             accepted,
	output logic [7:0]       active_node,
	output logic [7:0]       reported_node,
	output logic [31:0]      packet_total,
	output logic [31:0]      gap_ms,
	output logic             status_valid,
	output logic             node_healthy,
	output logic [31:0]      node_age_ms,
	output logic             primary_healthy,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import gnsst_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_DECIDE = 3'b100
	} state_t;

	state_t      state_q;
	scan_rec_t   chain [SLOTS+1];
	scan_rec_t   launch_q;
	scan_rec_t   hit_q;
	slot_wr_t    wr;
	logic        skip_q;
	logic [1:0]  mode_q;
	logic [7:0]  id_q;
	logic [31:0] now_q;

	logic        en_q;
	logic [7:0]  chosen_q;
	logic [15:0] timeout_q;
	logic [7:0]  pnode_q;
	logic [31:0] ptime_q;

	logic        out_valid_q;
	logic        found_q, fresh_q, acc_q, qvalid_q, qhealthy_q, phealthy_q;
	logic [2:0]  index_q;
	logic [7:0]  pnode_out_q, reported_q;
	logic [31:0] pkts_q, gap_q, qage_q;

	logic        in_fire, decide_fire, skip_in;
	logic        found, fresh, is_fix, enabled, acc, qvalid, qhealthy, phealthy;
	logic [31:0] prev_time, prev_pkts, pkts_inc, gap, p_age, qage, timeout_ext;
	logic [7:0]  new_pnode;

	assign in_ready    = (state_q == ST_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign decide_fire = (state_q == ST_DECIDE) && (!out_valid_q || out_ready);
	assign cfg_ready   = 1'b1;
	assign skip_in     = (mode != MODE_FIX && mode != MODE_AUX && mode != MODE_QUERY) ||
		node_id == 8'd0 || node_id == DISABLED_ID;

	// Slot chain
	assign chain[0] = launch_q;
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		gnsst_cell #(
			.INDEX       (g),
			.DISABLED_ID (DISABLED_ID)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.rec_in  (chain[g]),
			.rec_out (chain[g+1]),
			.wr      (wr)
		);
	end

	// Decision on the captured search result
	always_comb begin
		timeout_ext = {16'd0, timeout_q};
		found     = !skip_q && (hit_q.match || mode_q != MODE_QUERY);
		fresh     = found && !hit_q.match;
		is_fix    = found && mode_q == MODE_FIX;
		prev_time = hit_q.match ? hit_q.hit_time : 32'd0;
		prev_pkts = hit_q.match ? hit_q.hit_pkts : 32'd0;
		pkts_inc  = prev_pkts + 32'd1;
		gap       = is_fix ? now_q - prev_time : 32'd0;
		enabled   = en_q && chosen_q != DISABLED_ID;
		p_age     = (ptime_q != 32'd0) ? now_q - ptime_q : '1;
		if (chosen_q != AUTO_ID) begin
			acc = is_fix && enabled && chosen_q == id_q;
		end else begin
			acc = is_fix && enabled &&
				(pnode_q == DISABLED_ID || pnode_q == id_q || p_age > timeout_ext);
		end
		new_pnode = acc ? id_q : pnode_q;
		// a new primary stamped at time zero reads as never heard
		phealthy  = acc ? (now_q != 32'd0) : (enabled && p_age <= timeout_ext);
		qvalid    = found && mode_q == MODE_QUERY && hit_q.hit_time != 32'd0;
		qage      = qvalid ? now_q - hit_q.hit_time : 32'd0;
		qhealthy  = qvalid && qage <= timeout_ext;

		wr.en      = decide_fire && found && (is_fix || fresh);
		wr.idx     = hit_q.idx;
		wr.node    = id_q;
		wr.time_ms = is_fix ? now_q : 32'd0;
		wr.pkts    = is_fix ? pkts_inc : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= '0;
		end else begin
			launch_q.active <= in_fire && !skip_in;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						launch_q.done    <= 1'b0;
						launch_q.match   <= 1'b0;
						launch_q.vvalid  <= 1'b0;
						launch_q.node_id <= node_id;
						state_q          <= skip_in ? ST_DECIDE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chain[SLOTS].active) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (decide_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item fields and captured search result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q <= mode;
			id_q   <= node_id;
			now_q  <= now_ms;
			skip_q <= skip_in;
		end
		if (state_q == ST_SCAN && chain[SLOTS].active) begin
			hit_q <= chain[SLOTS];
		end
	end

	// Configuration and primary source
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= 1'b0;
			chosen_q  <= 8'd0;
			timeout_q <= TIMEOUT_RST;
			pnode_q   <= DISABLED_ID;
			ptime_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ENABLE:  en_q      <= cfg_data[0];
					CFG_CHOSEN:  chosen_q  <= cfg_data[7:0];
					CFG_TIMEOUT: timeout_q <= cfg_data;
					default: ;
				endcase
			end
			if (decide_fire && acc) begin
				pnode_q <= id_q;
				ptime_q <= now_q;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (decide_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decide_fire) begin
			found_q     <= found;
			index_q     <= found ? hit_q.idx[2:0] : 3'd0;
			fresh_q     <= fresh;
			acc_q       <= acc;
			pnode_out_q <= new_pnode;
			reported_q  <= (new_pnode != DISABLED_ID) ? new_pnode : chosen_q;
			pkts_q      <= found ? (is_fix ? pkts_inc : prev_pkts) : 32'd0;
			gap_q       <= gap;
			qvalid_q    <= qvalid;
			qhealthy_q  <= qhealthy;
			qage_q      <= qage;
			phealthy_q  <= phealthy;
		end
	end

	assign out_valid       = out_valid_q;
	assign slot_found      = found_q;
	assign slot_index      = index_q;
	assign slot_new        = fresh_q;
	assign accepted        = acc_q;
	assign active_node     = pnode_out_q;
	assign reported_node   = reported_q;
	assign packet_total    = pkts_q;
	assign gap_ms          = gap_q;
	assign status_valid    = qvalid_q;
	assign node_healthy    = qhealthy_q;
	assign node_age_ms     = qage_q;
	assign primary_healthy = phealthy_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("tracker took a second item while busy");

	a_new_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (slot_new || status_valid || accepted) |-> slot_found)
		else $error("slot flags set without a slot");

	a_accept_sets_primary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> active_node == reported_node && slot_found)
		else $error("accepted fix did not become the primary");

	a_decide_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> state_q == ST_IDLE && out_valid)
		else $error("slot write outside of a result hand-off");

endmodule

`default_nettype wire
